### rtl/mhc_pkg.sv
// ----------------------------------------------------------------------------
// mhc_pkg: shared types, constants and helpers for the magic hash check
// Table sizing, verdict codes, controller states and the small bit-count
// functions used by the collision check unit.
// ----------------------------------------------------------------------------
package mhc_pkg;

    // Depth of the pair store and of the used table; a power of two, so a
    // slot wraps by keeping its low index bits.
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int WORD_W  = 64;
    localparam int HALF_W  = WORD_W / 2;
    // Wide enough to hold a bit count of a whole word (0 to 64).
    localparam int SHIFT_W = $clog2(WORD_W + 1);

    // Epoch tags mark used-table entries written during the current walk.
    localparam int                 EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    localparam logic [3:0] PREFILTER_MIN = 4'd6;

    // Configuration port.
    localparam int               CFG_ADDR_W      = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_OCC_MASK = 4'h0;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_PREFILTER = 2'd1,
        VERDICT_COLLISION = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREF,
        ST_CLEAR,
        ST_WALK,
        ST_RESP
    } state_t;

    // Sideband that travels with each walked pair through the pipeline.
    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] attack;
    } walk_side_t;

    // Outcome of one pair at the end of the used-table check.
    typedef struct packed {
        logic valid;
        logic collision;
        logic last;
    } chk_status_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [SHIFT_W-1:0] pop64(input logic [WORD_W-1:0] v);
        logic [SHIFT_W-1:0] c;
        c = '0;
        for (int i = 0; i < WORD_W / 8; i++) begin
            c = c + SHIFT_W'(pop8(v[8*i +: 8]));
        end
        return c;
    endfunction

endpackage

### rtl/mhc_mul64lo.sv
// ----------------------------------------------------------------------------
// mhc_mul64lo: pipelined low-half 64 by 64 multiplier
// Three stages, one 32-bit multiply each: the low partial product first,
// then the two cross terms folded into the upper half.
// ----------------------------------------------------------------------------
module mhc_mul64lo
    import mhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              flush,
    input  logic              in_valid,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  walk_side_t        in_side,
    output logic              out_valid,
    output logic [WORD_W-1:0] prod,
    output walk_side_t        out_side
);

    logic              v1_reg, v2_reg, v3_reg;
    logic [WORD_W-1:0] ll_reg;
    logic [HALF_W-1:0] a_lo1_reg, b_hi1_reg, a_hi1_reg, b_lo1_reg;
    logic [HALF_W-1:0] a_hi2_reg, b_lo2_reg;
    logic [HALF_W-1:0] hi2_reg, lo2_reg, hi3_reg, lo3_reg;
    walk_side_t        side1_reg, side2_reg, side3_reg;

    logic [WORD_W-1:0] ll_full;
    logic [HALF_W-1:0] cross1, cross2;

    assign ll_full = WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
    assign cross1  = a_lo1_reg * b_hi1_reg;
    assign cross2  = a_hi2_reg * b_lo2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid && !flush;
            v2_reg <= v1_reg && !flush;
            v3_reg <= v2_reg && !flush;
        end
    end

    always_ff @(posedge aclk) begin
        ll_reg    <= ll_full;
        a_lo1_reg <= a[HALF_W-1:0];
        a_hi1_reg <= a[WORD_W-1:HALF_W];
        b_lo1_reg <= b[HALF_W-1:0];
        b_hi1_reg <= b[WORD_W-1:HALF_W];
        side1_reg <= in_side;

        hi2_reg   <= ll_reg[WORD_W-1:HALF_W] + cross1;
        lo2_reg   <= ll_reg[HALF_W-1:0];
        a_hi2_reg <= a_hi1_reg;
        b_lo2_reg <= b_lo1_reg;
        side2_reg <= side1_reg;

        hi3_reg   <= hi2_reg + cross2;
        lo3_reg   <= lo2_reg;
        side3_reg <= side2_reg;
    end

    assign out_valid = v3_reg;
    assign prod      = {hi3_reg, lo3_reg};
    assign out_side  = side3_reg;

endmodule

### rtl/mhc_pair_store.sv
// ----------------------------------------------------------------------------
// mhc_pair_store: blocker-board and attack-map store
// One synchronous memory holding both halves of each pair, written by loads
// and read in index order during a walk.
// ----------------------------------------------------------------------------
module mhc_pair_store
    import mhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              flush,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_blocker,
    input  logic [WORD_W-1:0] wr_attack,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic              rd_last,
    output logic              rd_valid,
    output logic [WORD_W-1:0] rd_blocker,
    output walk_side_t        rd_side
);

    logic [2*WORD_W-1:0] pair_mem [TABLE_DEPTH];
    logic [2*WORD_W-1:0] rd_data_reg;
    logic                rd_last_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pair_mem[wr_addr] <= {wr_attack, wr_blocker};
        end
        if (rd_en) begin
            rd_data_reg <= pair_mem[rd_addr];
        end
        rd_last_reg <= rd_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en && !flush;
        end
    end

    assign rd_valid       = rd_valid_reg;
    assign rd_blocker     = rd_data_reg[WORD_W-1:0];
    assign rd_side.attack = rd_data_reg[2*WORD_W-1:WORD_W];
    assign rd_side.last   = rd_last_reg;

endmodule

### rtl/mhc_used_check.sv
// ----------------------------------------------------------------------------
// mhc_used_check: slot extraction and used-table read-modify-write
// Takes each hashed product, picks its slot, reads the epoch-tagged used
// table, forwards the previous write and reports a collision.
// ----------------------------------------------------------------------------
module mhc_used_check
    import mhc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               flush,
    input  logic               in_valid,
    input  logic [WORD_W-1:0]  prod,
    input  walk_side_t         in_side,
    input  logic [SHIFT_W-1:0] n_bits,
    input  logic [EPOCH_W-1:0] epoch,
    input  logic               clr_en,
    input  logic [IDX_W-1:0]   clr_addr,
    output chk_status_t        status
);

    localparam int USED_W = EPOCH_W + WORD_W;

    logic [USED_W-1:0] used_mem [TABLE_DEPTH];

    logic               a_valid_reg, b_valid_reg;
    logic [IDX_W-1:0]   slot_a_reg, slot_b_reg;
    walk_side_t         side_a_reg, side_b_reg;
    logic [USED_W-1:0]  rdata_reg;

    logic               fw_valid_reg;
    logic [IDX_W-1:0]   fw_slot_reg;
    logic [WORD_W-1:0]  fw_data_reg;

    logic [SHIFT_W-1:0] shamt;
    logic [WORD_W-1:0]  shifted;
    logic               tag_hit;
    logic [WORD_W-1:0]  current;
    logic               wr_en;
    logic               collide;

    // A shift by the full word width leaves zero, which covers the empty mask.
    assign shamt   = SHIFT_W'(WORD_W) - n_bits;
    assign shifted = prod >> shamt;

    // The entry written by the previous pair is not yet in the read data.
    assign tag_hit = (rdata_reg[USED_W-1:WORD_W] == epoch);
    always_comb begin
        if (fw_valid_reg && (fw_slot_reg == slot_b_reg)) begin
            current = fw_data_reg;
        end else if (tag_hit) begin
            current = rdata_reg[WORD_W-1:0];
        end else begin
            current = '0;
        end
    end

    assign wr_en   = b_valid_reg && (current == '0);
    assign collide = b_valid_reg && (current != '0) && (current != side_b_reg.attack);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
        end else begin
            a_valid_reg  <= in_valid && !flush;
            b_valid_reg  <= a_valid_reg && !flush;
            fw_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        slot_a_reg  <= shifted[IDX_W-1:0];
        side_a_reg  <= in_side;
        slot_b_reg  <= slot_a_reg;
        side_b_reg  <= side_a_reg;
        rdata_reg   <= used_mem[slot_a_reg];
        fw_slot_reg <= slot_b_reg;
        fw_data_reg <= side_b_reg.attack;
        if (clr_en) begin
            used_mem[clr_addr] <= '0;
        end else if (wr_en) begin
            used_mem[slot_b_reg] <= {epoch, side_b_reg.attack};
        end
    end

    assign status.valid     = b_valid_reg;
    assign status.collision = collide;
    assign status.last      = side_b_reg.last;

endmodule

### rtl/magic_hash_collision_check_unit.sv
// ----------------------------------------------------------------------------
// magic_hash_collision_check_unit: magic-number collision tester
// Holds blocker-board / attack-map pairs and tests candidate magics against
// them: a top-byte prefilter, then a hashed walk over the used table.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Contents
//  s_        in         s_tvalid / s_tready   load or test word
//  m_        out        m_tvalid / m_tready   verdict and accepted magic
//  APB       in/out     psel / penable        occupancy mask at byte 0x0
//
// A test word runs the mask product through the three-stage multiplier and,
// when the prefilter passes, walks W = min(2^n, 4096) pairs at one pair per
// cycle; a collision ends the walk early. The first walk after reset, and
// every 255th walk after it, is preceded by a clearing pass over all 4096
// entries of the used table, which zeroes their epoch tags.
// Reset is synchronous and active low; the stores are not cleared by it.
// A result that is not taken holds the next test's result back, and no
// loads are accepted while it waits.
// ----------------------------------------------------------------------------
module magic_hash_collision_check_unit
    import mhc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // bits from 0: entry_index[11:0], blocker_board[63:0], attack_map[63:0],
    // candidate_magic[63:0], four zero bits
    input  logic [207:0]          s_tdata,
    // bit 0: req_type
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bits from 0: verdict[1:0], accepted_magic[63:0], six zero bits
    output logic [71:0]           m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

    // Input word fields.
    logic [11:0]       in_entry_index;
    logic [WORD_W-1:0] in_blocker;
    logic [WORD_W-1:0] in_attack;
    logic [WORD_W-1:0] in_magic;

    assign in_entry_index = s_tdata[11:0];
    assign in_blocker     = s_tdata[75:12];
    assign in_attack      = s_tdata[139:76];
    assign in_magic       = s_tdata[203:140];

    // Configuration register. It spans eight bytes, so the address bits
    // from bit 3 upwards pick the register.
    logic [WORD_W-1:0] mask_reg;
    logic              cfg_sel;

    assign cfg_sel = (paddr[CFG_ADDR_W-1:3] == REG_OCC_MASK[CFG_ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? mask_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            mask_reg <= pwdata;
        end
    end

    // Controller state.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               issuing_reg, issuing_next;
    logic [IDX_W-1:0]   walk_last_reg, walk_last_next;
    logic [SHIFT_W-1:0] n_reg, n_next;
    logic [WORD_W-1:0]  magic_reg, magic_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    verdict_t           verdict_reg, verdict_next;

    // Output register, which parts the walk from the result consumer.
    logic               m_tvalid_reg, m_tvalid_next;
    verdict_t           out_verdict_reg, out_verdict_next;
    logic [WORD_W-1:0]  out_magic_reg, out_magic_next;

    logic               s_accept;
    logic               test_start;
    logic               load_en;
    logic               rd_en;
    logic               clr_en;
    logic               flush;

    logic               pair_valid;
    logic [WORD_W-1:0]  pair_blocker;
    walk_side_t         pair_side;

    logic               mul_in_valid;
    logic [WORD_W-1:0]  mul_a, mul_b;
    logic               mul_out_valid;
    logic [WORD_W-1:0]  mul_prod;
    walk_side_t         mul_side;

    chk_status_t        chk_status;

    assign s_accept   = s_tvalid && s_tready;
    assign test_start = s_accept && s_tuser;
    // Indices past the end of the store are dropped.
    assign load_en    = s_accept && !s_tuser
                        && (32'(in_entry_index) < 32'(TABLE_DEPTH));

    // The multiplier first forms mask * magic for the prefilter, then the
    // blocker products of the walk.
    assign mul_in_valid = test_start || pair_valid;
    assign mul_a        = test_start ? mask_reg : pair_blocker;
    assign mul_b        = test_start ? in_magic : magic_reg;

    always_comb begin
        state_next       = state_reg;
        k_next           = k_reg;
        issuing_next     = issuing_reg;
        walk_last_next   = walk_last_reg;
        n_next           = n_reg;
        magic_next       = magic_reg;
        epoch_next       = epoch_reg;
        clr_cnt_next     = clr_cnt_reg;
        verdict_next     = verdict_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_verdict_next = out_verdict_reg;
        out_magic_next   = out_magic_reg;
        s_tready         = 1'b0;
        rd_en            = 1'b0;
        clr_en           = 1'b0;
        flush            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser) begin
                    magic_next = in_magic;
                    n_next     = pop64(mask_reg);
                    // Low n index bits set, or all of them once n reaches
                    // the index width: the walk covers min(2^n, depth).
                    walk_last_next = ~({IDX_W{1'b1}} << pop64(mask_reg));
                    state_next = ST_PREF;
                end
            end

            ST_PREF: begin
                if (mul_out_valid) begin
                    if (pop8(mul_prod[WORD_W-1:WORD_W-8]) < PREFILTER_MIN) begin
                        verdict_next = VERDICT_PREFILTER;
                        state_next   = ST_RESP;
                    end else if (epoch_reg == EPOCH_MAX) begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end else begin
                        epoch_next   = epoch_reg + EPOCH_FIRST;
                        k_next       = '0;
                        issuing_next = 1'b1;
                        state_next   = ST_WALK;
                    end
                end
            end

            ST_CLEAR: begin
                // Tag zero never matches a live epoch, so every entry reads
                // as empty afterwards.
                clr_en = 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    epoch_next   = EPOCH_FIRST;
                    k_next       = '0;
                    issuing_next = 1'b1;
                    state_next   = ST_WALK;
                end else begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            ST_WALK: begin
                rd_en = issuing_reg;
                if (issuing_reg) begin
                    if (k_reg == walk_last_reg) begin
                        issuing_next = 1'b0;
                    end else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
                if (chk_status.valid) begin
                    if (chk_status.collision) begin
                        // Drop every pair still in flight behind this one.
                        flush        = 1'b1;
                        issuing_next = 1'b0;
                        verdict_next = VERDICT_COLLISION;
                        state_next   = ST_RESP;
                    end else if (chk_status.last) begin
                        verdict_next = VERDICT_ACCEPT;
                        state_next   = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next    = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_magic_next   = (verdict_reg == VERDICT_ACCEPT) ? magic_reg : '0;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issuing_reg  <= 1'b0;
            k_reg        <= '0;
            clr_cnt_reg  <= '0;
            // Starting at the top epoch makes the first walk clear the table.
            epoch_reg    <= EPOCH_MAX;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issuing_reg  <= issuing_next;
            k_reg        <= k_next;
            clr_cnt_reg  <= clr_cnt_next;
            epoch_reg    <= epoch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_last_reg   <= walk_last_next;
        n_reg           <= n_next;
        magic_reg       <= magic_next;
        verdict_reg     <= verdict_next;
        out_verdict_reg <= out_verdict_next;
        out_magic_reg   <= out_magic_next;
    end

    mhc_pair_store u_pair_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (flush),
        .wr_en      (load_en),
        .wr_addr    (in_entry_index[IDX_W-1:0]),
        .wr_blocker (in_blocker),
        .wr_attack  (in_attack),
        .rd_en      (rd_en),
        .rd_addr    (k_reg),
        .rd_last    (k_reg == walk_last_reg),
        .rd_valid   (pair_valid),
        .rd_blocker (pair_blocker),
        .rd_side    (pair_side)
    );

    mhc_mul64lo u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flush     (flush),
        .in_valid  (mul_in_valid),
        .a         (mul_a),
        .b         (mul_b),
        .in_side   (pair_side),
        .out_valid (mul_out_valid),
        .prod      (mul_prod),
        .out_side  (mul_side)
    );

    // Prefilter products leave the multiplier in the prefilter state and are
    // not passed on to the used-table check.
    mhc_used_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flush    (flush),
        .in_valid (mul_out_valid && (state_reg == ST_WALK)),
        .prod     (mul_prod),
        .in_side  (mul_side),
        .n_bits   (n_reg),
        .epoch    (epoch_reg),
        .clr_en   (clr_en),
        .clr_addr (clr_cnt_reg),
        .status   (chk_status)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_magic_reg, out_verdict_reg};

    // A checked pair only ever appears while a walk is in progress; a pair
    // left over from an aborted walk would show up here.
    a_status_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_status.valid |-> (state_reg == ST_WALK))
        else $error("used-table check active outside a walk");

    // Pair reads are only issued during a walk.
    a_issue_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        issuing_reg |-> (state_reg == ST_WALK))
        else $error("pair read issued outside a walk");

    // A walk never runs with the epoch that marks cleared entries.
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (epoch_reg != '0))
        else $error("walk running with the cleared epoch tag");

    // Only an accepted magic is reported; other verdicts carry zero.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_verdict_reg != VERDICT_ACCEPT)) |-> (out_magic_reg == '0))
        else $error("rejected magic reported with a nonzero value");

endmodule

### tb/magic_hash_collision_check_unit_tb.sv
// ----------------------------------------------------------------------------
// magic_hash_collision_check_unit_tb: self-checking bench for the magic tester
// Loads blocker-board / attack-map pairs, tests candidate magics under a range
// of occupancy masks, and checks every verdict word against a behavioural
// predictor kept inside the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module magic_hash_collision_check_unit_tb;
    import mhc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds carried on s_tuser.
    localparam bit REQ_LOAD = 1'b0;
    localparam bit REQ_TEST = 1'b1;

    localparam logic [63:0] TOP_BYTE = 64'hFF00_0000_0000_0000;

    // Cycles without any accepted word before the run is declared hung. The
    // worst honest gap is a clearing pass of the used table plus a walk.
    localparam int QUIET_LIMIT = 30000;

    // How attack maps are derived from blocker boards in a well-formed set.
    typedef enum int {
        MAP_FLAT,    // one map for every board: the walk can never collide
        MAP_COARSE,  // map depends on a few mask bits only, sometimes zero
        MAP_NOISY    // unrelated map per board: collisions are likely
    } map_style_t;

    // One stream word as the sender holds it, with its idling settings.
    typedef struct {
        bit          req;
        logic [11:0] index;
        logic [63:0] board;
        logic [63:0] attack;
        logic [63:0] magic;
        bit          drain;      // hold back until every verdict is in
        int          gap_pct;    // chance in 100 that the sender idles
        int          stall_pct;  // receiver stall chance once this is taken
    } stream_word_t;

    typedef struct {
        verdict_t    verdict;
        logic [63:0] magic;
    } hash_verdict_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // bits from 0: entry_index[11:0], blocker_board[63:0], attack_map[63:0],
    // candidate_magic[63:0], four zero bits
    logic [207:0]          s_tdata  = '0;
    // bit 0: req_type
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // bits from 0: verdict[1:0], accepted_magic[63:0], six zero bits
    logic [71:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [WORD_W-1:0]     pwdata   = '0;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;

    // Predictor state: the mask as last written and the two pair stores.
    logic [63:0]   occ_mask = '0;
    logic [63:0]   board_mem  [TABLE_DEPTH];
    logic [63:0]   attack_mem [TABLE_DEPTH];
    logic [63:0]   slot_map   [TABLE_DEPTH];

    stream_word_t  word_queue[$];
    hash_verdict_t verdict_queue[$];
    stream_word_t  cur_word;

    // Entries written so far, so that no walk ever reads an unwritten pair.
    bit            filled [TABLE_DEPTH];

    int tests_issued  = 0;
    int verdicts_seen = 0;
    int failures      = 0;
    int quiet_cycles  = 0;
    int ready_gap     = 52;
    int gen_gap       = 8;
    int gen_stall     = 52;
    int gen_items     = 0;

    magic_hash_collision_check_unit uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // The prefilter: at least six set bits in the top byte of mask * magic.
    function automatic bit top_byte_ok(input logic [63:0] mask, input logic [63:0] magic);
        return $countones((mask * magic) & TOP_BYTE) >= PREFILTER_MIN;
    endfunction

    // Expected verdict for a test word under the current mask and stores.
    function automatic hash_verdict_t judge_magic(input logic [63:0] magic);
        hash_verdict_t       res;
        logic [63:0]         product;
        logic [IDX_W-1:0]    slot;
        int                  n;
        int                  span;
        bit                  clash;
        res.magic = '0;
        if (!top_byte_ok(occ_mask, magic)) begin
            res.verdict = VERDICT_PREFILTER;
            return res;
        end
        n     = $countones(occ_mask);
        span  = (n >= IDX_W) ? TABLE_DEPTH : (1 << n);
        clash = 1'b0;
        foreach (slot_map[i]) slot_map[i] = '0;
        for (int k = 0; k < span && !clash; k++) begin
            product = board_mem[k] * magic;
            // Slots beyond the table wrap, which keeping the low bits does.
            slot = (n == 0) ? '0 : IDX_W'(product >> (64 - n));
            if (slot_map[slot] == '0) begin
                slot_map[slot] = attack_mem[k];
            end else if (slot_map[slot] != attack_mem[k]) begin
                clash = 1'b1;
            end
        end
        if (clash) begin
            res.verdict = VERDICT_COLLISION;
        end else begin
            res.verdict = VERDICT_ACCEPT;
            res.magic   = magic;
        end
        return res;
    endfunction

    // Places the bits of code, lowest first, on the set bits of the mask.
    function automatic logic [63:0] spread_bits(input logic [63:0] mask, input int unsigned code);
        logic [63:0] board;
        int          j;
        board = '0;
        j     = 0;
        for (int b = 0; b < 64; b++) begin
            if (mask[b]) begin
                board[b] = (j < 32) ? code[j] : 1'b0;
                j++;
            end
        end
        return board;
    endfunction

    // Draws candidates, sparse ones mostly, and optionally keeps drawing
    // until one gets past the prefilter for this mask.
    function automatic logic [63:0] pick_magic(input logic [63:0] mask, input bit want_pass);
        logic [63:0] cand;
        cand = '0;
        for (int t = 0; t < 200; t++) begin
            case ($urandom_range(2))
                0: cand = rand64() & rand64() & rand64();
                1: cand = rand64() & rand64();
                default: cand = rand64();
            endcase
            if (!want_pass || top_byte_ok(mask, cand)) break;
        end
        return cand;
    endfunction

    function automatic logic [63:0] attack_for(input logic [63:0] board, input map_style_t style,
                                               input logic [63:0] sub, input logic [63:0] salt);
        case (style)
            MAP_FLAT:  return salt;
            MAP_NOISY: return rand64();
            default:   return ($urandom_range(7) == 0) ? '0 : ((board & sub) ^ salt);
        endcase
    endfunction

    function automatic bit table_ready(input int span);
        for (int i = 0; i < span; i++) begin
            if (!filled[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_word(input bit req, input logic [11:0] index,
                                       input logic [63:0] board, input logic [63:0] attack,
                                       input logic [63:0] magic, input bit drain);
        stream_word_t w;
        w.req       = req;
        w.index     = index;
        w.board     = board;
        w.attack    = attack;
        w.magic     = magic;
        w.drain     = drain;
        w.gap_pct   = gen_gap;
        w.stall_pct = gen_stall;
        word_queue.push_back(w);
        gen_items++;
        if (req == REQ_LOAD) begin
            filled[index] = 1'b1;
        end
    endfunction

    // Waits until the block has nothing left to do: every word sent, every
    // verdict back, and a margin for a load still in the pipeline.
    task automatic settle();
        do @(negedge aclk);
        while (word_queue.size() != 0 || s_tvalid || tests_issued != verdicts_seen);
        repeat (32) @(posedge aclk);
    endtask

    // APB write of the occupancy mask: a setup phase, then access until pready.
    task automatic write_mask(input logic [63:0] value);
        settle();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_OCC_MASK;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        occ_mask = value;
        @(negedge aclk);
    endtask

    // A well-formed set: a mask of a few bits, every subset of it loaded as a
    // blocker board in shuffled order, then several candidate tests. Stray
    // loads and early tests make up the broken part of the sequence.
    task automatic pairs_phase();
        logic [63:0] mask;
        logic [63:0] sub;
        logic [63:0] salt;
        logic [63:0] board;
        map_style_t  style;
        int          order [256];
        int          n;
        int          span;
        int          j;
        int          tmp;
        int          tests;
        n    = ($urandom_range(7) == 0) ? 5 : $urandom_range(1, 4);
        mask = '0;
        while ($countones(mask) < n) mask[$urandom_range(63)] = 1'b1;
        write_mask(mask);
        span = 1 << n;
        case ($urandom_range(3))
            0: style = MAP_FLAT;
            3: style = MAP_NOISY;
            default: style = MAP_COARSE;
        endcase
        sub  = mask & rand64();
        salt = rand64() | 64'h1;
        for (int k = 0; k < span; k++) order[k] = k;
        for (int k = span - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < span; k++) begin
            if ($urandom_range(15) == 0 && table_ready(span)) begin
                queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(),
                           pick_magic(mask, 1'b1), 1'b0);
            end
            if ($urandom_range(9) == 0) begin
                queue_word(REQ_LOAD, 12'($urandom_range(4095)), rand64(), rand64(),
                           rand64(), 1'b0);
            end
            board = spread_bits(mask, order[k]);
            queue_word(REQ_LOAD, 12'(order[k]), board, attack_for(board, style, sub, salt),
                       rand64(), 1'b0);
        end
        tests = $urandom_range(3, 6);
        for (int t = 0; t < tests; t++) begin
            // A stray load inside the walked range spoils the set on purpose.
            if ($urandom_range(3) == 0) begin
                queue_word(REQ_LOAD, 12'($urandom_range(span - 1)), rand64(), rand64(),
                           rand64(), 1'b0);
            end
            queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(),
                       pick_magic(mask, $urandom_range(9) < 7),
                       t == 0 && $urandom_range(3) == 0);
        end
    endtask

    // Sender: presents the next pending word once the current one is taken.
    // The prediction is made at the moment a word is accepted, which keeps it
    // in step with the block's own ordering of loads and tests.
    always @(posedge aclk) begin : drive_words
        bit taken;
        bit send;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) begin
                if (cur_word.req == REQ_LOAD) begin
                    board_mem[cur_word.index]  = cur_word.board;
                    attack_mem[cur_word.index] = cur_word.attack;
                end else begin
                    verdict_queue.push_back(judge_magic(cur_word.magic));
                    tests_issued <= tests_issued + 1;
                end
                ready_gap <= cur_word.stall_pct;
            end
            if (taken || !s_tvalid) begin
                send = word_queue.size() != 0;
                // A draining word waits until no test is still outstanding.
                if (send && word_queue[0].drain) begin
                    send = tests_issued == verdicts_seen && !(taken && cur_word.req == REQ_TEST);
                end
                if (send && $urandom_range(99) < word_queue[0].gap_pct) begin
                    send = 1'b0;
                end
                if (send) begin
                    cur_word = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cur_word.magic, cur_word.attack, cur_word.board,
                                 cur_word.index};
                    s_tuser  <= cur_word.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: takes verdict words, stalling at random, and compares each
    // with the oldest prediction still waiting.
    always @(posedge aclk) begin : check_verdicts
        hash_verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                verdicts_seen <= verdicts_seen + 1;
                if (verdict_queue.size() == 0) begin
                    $error("verdict word %h arrived with no test outstanding", m_tdata);
                    failures++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (m_tdata[1:0] !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                        failures++;
                    end
                    if (m_tdata[65:2] !== want.magic) begin
                        $error("accepted_magic: expected %h, got %h", want.magic, m_tdata[65:2]);
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= ready_gap);
        end
    end

    // Watchdog on progress: any accepted word on either side restarts it.
    always @(posedge aclk) begin : watch_progress
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("magic_hash_collision_check_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. The mask resets to zero, so the product is zero and
        // both of the first tests must fall at the prefilter.
        gen_gap   = 8;
        gen_stall = 52;
        queue_word(REQ_TEST, 12'hFFF, '1, '1, '1, 1'b0);
        queue_word(REQ_TEST, 12'h000, '0, '0, '0, 1'b0);
        write_mask('0);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(), rand64(), 1'b0);

        // A three-bit mask with one shared all-ones map: a candidate that
        // passes the prefilter has to be accepted.
        write_mask(64'h8000_0010_0000_0001);
        for (int k = 0; k < 8; k++) begin
            queue_word(REQ_LOAD, 12'(k), spread_bits(occ_mask, k), '1, rand64(), 1'b0);
        end
        queue_word(REQ_LOAD, 12'd7, '1, '1, '0, 1'b0);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(),
                   pick_magic(occ_mask, 1'b1), 1'b1);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(), '1, 1'b0);
        // A zero attack map leaves its slot looking empty.
        queue_word(REQ_LOAD, 12'd5, spread_bits(occ_mask, 5), '0, rand64(), 1'b0);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(),
                   pick_magic(occ_mask, 1'b1), 1'b0);
        // A differing map: the walk may now find a collision.
        queue_word(REQ_LOAD, 12'd6, spread_bits(occ_mask, 6), rand64(), rand64(), 1'b0);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(),
                   pick_magic(occ_mask, 1'b1), 1'b0);
        // The top entry lies outside this walk, and a zero magic never passes.
        queue_word(REQ_LOAD, 12'hFFF, '0, '1, '1, 1'b0);
        queue_word(REQ_TEST, 12'($urandom_range(4095)), rand64(), rand64(), '0, 1'b0);

        // Random part: idling on the receiver first, then on the sender, then
        // on neither side.
        while (gen_items < 140) begin
            if (gen_items < 60) begin
                gen_gap   = 8;
                gen_stall = 52;
            end else if (gen_items < 100) begin
                gen_gap   = 52;
                gen_stall = 8;
            end else begin
                gen_gap   = 0;
                gen_stall = 0;
            end
            pairs_phase();
        end

        settle();
        repeat (32) @(posedge aclk);
        if (verdict_queue.size() != 0) begin
            $error("%0d test verdicts never arrived", verdict_queue.size());
            failures++;
        end
        if (failures == 0) begin
            $display("magic_hash_collision_check_unit verification clean");
        end else begin
            $display("magic_hash_collision_check_unit verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mhc_pkg.sv
rtl/mhc_mul64lo.sv
rtl/mhc_pair_store.sv
rtl/mhc_used_check.sv
rtl/magic_hash_collision_check_unit.sv
tb/magic_hash_collision_check_unit_tb.sv
